// ===== sv/hflt_pkg.sv =====
// Package: shared types and constants of the hex float literal converter.
`default_nettype none
package hflt_pkg;

    // Literal kinds
    localparam logic [1:0] KIND_HEX = 2'd0;
    localparam logic [1:0] KIND_INF = 2'd1;
    localparam logic [1:0] KIND_NAN = 2'd2;
    localparam logic [1:0] KIND_BAD = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam int unsigned NIBBLE_BITS = 4;

    // Encodings
    localparam logic [63:0] F32_QNAN      = 64'h0000_0000_0040_0000;
    localparam logic [63:0] F64_QNAN      = 64'h0008_0000_0000_0000;
    localparam logic [63:0] F32_FRAC_MASK = 64'h0000_0000_007f_ffff;
    localparam logic [63:0] F64_FRAC_MASK = 64'h000f_ffff_ffff_ffff;
    localparam logic [63:0] F32_EXP_ALL   = 64'h0000_0000_7f80_0000;
    localparam logic [63:0] F64_EXP_ALL   = 64'h7ff0_0000_0000_0000;

    // Exponent limits (unbiased range endpoints)
    localparam int F32_EMAX = 127;
    localparam int F64_EMAX = 1023;
    localparam int F32_EMIN = -126;
    localparam int F64_EMIN = -1022;
    localparam int F32_P    = 24;
    localparam int F64_P    = 53;

    // Queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0] command;
        logic       double_precision;
        logic [7:0] character;
        logic       last_char;
    } t_req;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        ok;
    } t_res;

    // One finished literal, handed from front to back
    typedef struct packed {
        logic               special;  // bits already final in acc
        logic               ok;
        logic               neg;
        logic               wide;
        logic [63:0]        acc;
        logic signed [16:0] exps;
        logic signed [15:0] dot;
    } t_rec;

endpackage
`default_nettype wire

// ===== sv/hflt_front.sv =====
// Front end: per-character literal parser, emits one record per literal.
`default_nettype none
module hflt_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  hflt_pkg::t_req       i_req,
    output logic                 o_push,
    output hflt_pkg::t_rec       o_rec
);

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_SKIP    = 8'b0000_0010,
        PH_TAGPFX  = 8'b0000_0100,
        PH_PAYLOAD = 8'b0000_1000,
        PH_MANT    = 8'b0001_0000,
        PH_EXPSIGN = 8'b0010_0000,
        PH_EXPDIG  = 8'b0100_0000,
        PH_IGNORE  = 8'b1000_0000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [1:0]         r_kind, n_kind;
    logic               r_wide, n_wide;
    logic               r_dot_seen, n_dot_seen;
    logic [63:0]        r_acc, n_acc;
    logic [15:0]        r_pend, n_pend;
    logic [7:0]         r_width, n_width;
    logic signed [15:0] r_dot, n_dot;
    logic [15:0]        r_exp, n_exp;
    logic               r_exp_neg, n_exp_neg;
    logic               r_perr, n_perr;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)       return 16'sh7fff;
        else if (v < -18'sd32768) return 16'sh8000;
        else                      return v[15:0];
    endfunction

    function automatic logic [15:0] exp_step(input logic [15:0] e, input logic [7:0] c);
        logic [19:0] v;
        v = ({4'd0, e} << 3) + ({4'd0, e} << 1) + {16'd0, 4'(c - hflt_pkg::CH_ZERO)};
        if (c < hflt_pkg::CH_ZERO || c > hflt_pkg::CH_NINE) return e;
        else if (v > 20'd65535)                             return 16'hffff;
        else                                                return v[15:0];
    endfunction

    logic [7:0]  c;
    logic        is_hex;
    logic [3:0]  dig;
    logic [7:0]  lim;
    logic [1:0]  len;
    logic [7:0]  w_dec;
    logic [7:0]  want;
    logic [63:0] pay;
    logic [16:0] p_sum;
    logic [15:0] p2;
    logic [63:0] sig_mask;
    logic signed [15:0] dot_fin;
    logic [63:0] sign_bits, exp_all, qnan;
    logic        nan_bad;

    always_comb begin
        c = i_req.character;
        is_hex = 1'b1;
        dig = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)      dig = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) dig = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) dig = 4'(c - 8'h37);
        else                               is_hex = 1'b0;
    end

    always_comb begin
        n_phase = r_phase; n_neg = r_neg; n_kind = r_kind; n_wide = r_wide;
        n_dot_seen = r_dot_seen; n_acc = r_acc; n_pend = r_pend; n_width = r_width;
        n_dot = r_dot; n_exp = r_exp; n_exp_neg = r_exp_neg; n_perr = r_perr;
        lim = r_wide ? 8'd57 : 8'd28;
        sig_mask = r_wide ? hflt_pkg::F64_FRAC_MASK : hflt_pkg::F32_FRAC_MASK;
        len = 2'd0; w_dec = 8'd0; want = 8'd0; pay = 64'd0;
        p_sum = {1'b0, r_pend} + 17'(hflt_pkg::NIBBLE_BITS);
        p2 = p_sum[16] ? 16'hffff : p_sum[15:0];
        unique case (r_phase)
            PH_START: begin
                n_neg = 1'b0; n_dot_seen = 1'b0; n_acc = '0; n_pend = '0;
                n_width = '0; n_dot = '0; n_exp = '0; n_exp_neg = 1'b0; n_perr = 1'b0;
                n_kind = i_req.command;
                n_wide = i_req.double_precision;
                len = (i_req.command == hflt_pkg::KIND_HEX) ? 2'd2 : 2'd3;
                if (c == hflt_pkg::CH_MINUS || c == hflt_pkg::CH_PLUS) begin
                    n_neg = (c == hflt_pkg::CH_MINUS);
                end else begin
                    len = len - 2'd1;
                end
                if (i_req.command == hflt_pkg::KIND_INF
                        || i_req.command == hflt_pkg::KIND_BAD) begin
                    n_phase = PH_IGNORE;
                end else begin
                    n_width = {6'd0, len};
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                w_dec = (r_width != 8'd0) ? r_width - 8'd1 : r_width;
                n_width = w_dec;
                if (w_dec == 8'd0) begin
                    n_acc = '0;
                    if (r_kind == hflt_pkg::KIND_HEX)      n_phase = PH_MANT;
                    else if (r_kind == hflt_pkg::KIND_NAN) n_phase = PH_TAGPFX;
                    else                                   n_phase = PH_IGNORE;
                end
            end
            PH_TAGPFX: begin
                want = (r_width == 8'd0) ? hflt_pkg::CH_COLON
                     : (r_width == 8'd1) ? hflt_pkg::CH_ZERO : hflt_pkg::CH_X;
                if (c != want) begin
                    n_perr = 1'b1;
                    n_phase = PH_IGNORE;
                end else begin
                    n_width = r_width + 8'd1;
                    if (r_width + 8'd1 >= 8'd3) begin
                        n_phase = PH_PAYLOAD;
                        n_acc = '0;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (!r_perr) begin
                    if (!is_hex) begin
                        n_perr = 1'b1;
                    end else begin
                        pay = {r_acc[59:0], dig};
                        n_acc = pay;
                        if (pay > sig_mask) n_perr = 1'b1;
                    end
                end
            end
            PH_MANT: begin
                if (c == hflt_pkg::CH_DOT) begin
                    if (r_acc != 64'd0) n_dot = sat16(18'(r_dot) + $signed({2'b0, r_pend}));
                    n_pend = '0;
                    n_dot_seen = 1'b1;
                end else if (!is_hex) begin
                    if (!r_dot_seen) n_dot = sat16(18'(r_dot) + $signed({2'b0, r_pend}));
                    n_phase = PH_EXPSIGN;
                end else begin
                    n_pend = p2;
                    if (dig != 4'd0 && (r_acc == 64'd0
                            || ({9'd0, r_width} + {1'b0, p2}) <= {9'd0, lim})) begin
                        n_acc = ((r_acc != 64'd0) ? (r_acc << p2[5:0]) : r_acc)
                              | {60'd0, dig};
                        if (r_dot_seen) n_dot = sat16(18'(r_dot) - $signed({2'b0, p2}));
                        n_pend = '0;
                        n_width = r_width + 8'(hflt_pkg::NIBBLE_BITS);
                    end
                end
            end
            PH_EXPSIGN: begin
                if (c == hflt_pkg::CH_MINUS) n_exp_neg = 1'b1;
                else                         n_exp = exp_step(r_exp, c);
                n_phase = PH_EXPDIG;
            end
            PH_EXPDIG: n_exp = exp_step(r_exp, c);
            PH_IGNORE: ;
            default: ;
        endcase
        if (i_req.last_char) n_phase = PH_START;
    end

    // Build the record from the state after this character
    always_comb begin
        dot_fin = n_dot;
        if (n_phase == PH_MANT || (i_req.last_char && r_phase == PH_MANT
                && !(c == hflt_pkg::CH_DOT) && is_hex)) begin
            dot_fin = n_dot_seen ? n_dot : sat16(18'(n_dot) + $signed({2'b0, n_pend}));
        end
        sign_bits = n_wide ? {n_neg, 63'd0} : {32'd0, n_neg, 31'd0};
        exp_all = n_wide ? hflt_pkg::F64_EXP_ALL : hflt_pkg::F32_EXP_ALL;
        qnan = n_wide ? hflt_pkg::F64_QNAN : hflt_pkg::F32_QNAN;
        // phase before forcing back to start: recompute from current step
        nan_bad = n_perr
            || (r_phase == PH_TAGPFX && n_width != 8'd0 && !(n_perr)
                && n_width < 8'd3)
            || (r_phase == PH_SKIP && 1'b0)
            || ((r_phase == PH_PAYLOAD || (r_phase == PH_TAGPFX && n_width >= 8'd3))
                && n_acc == 64'd0);
        o_rec.special = (n_kind != hflt_pkg::KIND_HEX);
        o_rec.ok = 1'b1;
        o_rec.neg = n_neg;
        o_rec.wide = n_wide;
        o_rec.acc = n_acc;
        o_rec.exps = n_exp_neg ? -$signed({1'b0, n_exp}) : $signed({1'b0, n_exp});
        o_rec.dot = dot_fin;
        unique case (n_kind)
            hflt_pkg::KIND_HEX: ;
            hflt_pkg::KIND_INF: o_rec.acc = sign_bits | exp_all;
            hflt_pkg::KIND_NAN: begin
                if (nan_bad) begin
                    o_rec.ok = 1'b0;
                    o_rec.acc = '0;
                end else if (r_phase == PH_PAYLOAD
                        || (r_phase == PH_TAGPFX && n_width >= 8'd3)) begin
                    o_rec.acc = sign_bits | exp_all | n_acc;
                end else begin
                    o_rec.acc = sign_bits | exp_all | qnan;
                end
            end
            hflt_pkg::KIND_BAD: begin
                o_rec.ok = 1'b0;
                o_rec.acc = '0;
            end
            default: ;
        endcase
        o_push = i_accept && i_req.last_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START; r_neg <= 1'b0; r_kind <= '0; r_wide <= 1'b0;
            r_dot_seen <= 1'b0; r_acc <= '0; r_pend <= '0; r_width <= '0;
            r_dot <= '0; r_exp <= '0; r_exp_neg <= 1'b0; r_perr <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase; r_neg <= n_neg; r_kind <= n_kind; r_wide <= n_wide;
            r_dot_seen <= n_dot_seen; r_acc <= n_acc; r_pend <= n_pend;
            r_width <= n_width; r_dot <= n_dot; r_exp <= n_exp;
            r_exp_neg <= n_exp_neg; r_perr <= n_perr;
        end
    end

endmodule
`default_nettype wire

// ===== sv/hflt_fifo.sv =====
// Short record queue between parser and converter.
`default_nettype none
module hflt_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  hflt_pkg::t_rec   i_rec,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_avail,
    output hflt_pkg::t_rec   o_rec
);

    hflt_pkg::t_rec r_mem [hflt_pkg::QDEPTH];
    logic [hflt_pkg::QAW-1:0] r_wp, r_rp;
    logic [hflt_pkg::QAW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (hflt_pkg::QAW+1)'(hflt_pkg::QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_rec   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (hflt_pkg::QAW+1)'(do_push) - (hflt_pkg::QAW+1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== sv/hflt_back.sv =====
// Back end: normalize, round and encode one literal record, pipelined.
`default_nettype none
module hflt_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_avail,
    input  hflt_pkg::t_rec   i_rec,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_stall,
    output hflt_pkg::t_res   o_res
);

    typedef enum logic [4:0] {
        CLS_SPEC = 5'b00001,
        CLS_ZERO = 5'b00010,
        CLS_INF  = 5'b00100,
        CLS_NORM = 5'b01000,
        CLS_SUB  = 5'b10000
    } t_cls;

    logic adv;

    // stage 1
    logic               r1_v;
    hflt_pkg::t_rec     r1_rec;
    logic signed [17:0] r1_e0;
    logic [7:0]         r1_nz;
    logic [2:0]         r1_msb [8];

    // stage 2
    logic               r2_v;
    t_cls               r2_cls;
    logic               r2_neg, r2_wide, r2_ok, r2_left;
    logic [6:0]         r2_amt;
    logic [11:0]        r2_eb;
    logic [63:0]        r2_acc;

    // stage 3
    logic               r3_v;
    t_cls               r3_cls;
    logic               r3_neg, r3_wide, r3_ok, r3_rnd;
    logic [11:0]        r3_eb;
    logic [63:0]        r3_q;

    logic               r_ov;
    hflt_pkg::t_res     r_res, n_res;

    assign adv     = !r_ov || !i_stall;
    assign o_pop   = adv && i_avail;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    // Stage 1: per-byte leading bit, combined exponent
    logic [7:0] n1_nz;
    logic [2:0] n1_msb [8];
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n1_nz[i] = |i_rec.acc[i*8 +: 8];
            n1_msb[i] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (i_rec.acc[i*8 + b]) n1_msb[i] = 3'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_rec <= i_rec;
            r1_e0  <= 18'(i_rec.exps) + 18'(i_rec.dot);
            r1_nz  <= n1_nz;
            for (int i = 0; i < 8; i++) r1_msb[i] <= n1_msb[i];
        end
    end

    // Stage 2: significant width, class and shift amount
    logic [6:0]         bits;
    logic signed [18:0] e, emax, emin, snorm, ssub, s;
    logic [11:0]        eb;
    t_cls               cls;
    always_comb begin
        bits = 7'd0;
        for (int i = 0; i < 8; i++) begin
            if (r1_nz[i]) bits = {i[2:0], r1_msb[i]} + 7'd1;
        end
        emax = r1_rec.wide ? 19'(hflt_pkg::F64_EMAX) : 19'(hflt_pkg::F32_EMAX);
        emin = r1_rec.wide ? 19'(hflt_pkg::F64_EMIN) : 19'(hflt_pkg::F32_EMIN);
        e = 19'(r1_e0) + $signed({12'd0, bits}) - 19'sd1;
        snorm = $signed({12'd0, bits})
              - (r1_rec.wide ? 19'(hflt_pkg::F64_P) : 19'(hflt_pkg::F32_P));
        ssub = (r1_rec.wide ? -19'sd1074 : -19'sd149) - 19'(r1_e0);
        eb = 12'(e + emax);
        s = 19'sd0;
        if (r1_rec.special)              cls = CLS_SPEC;
        else if (r1_rec.acc == 64'd0)    cls = CLS_ZERO;
        else if (e > emax)               cls = CLS_INF;
        else if (e >= emin) begin
            cls = CLS_NORM;
            s = snorm;
        end else if (ssub > $signed({12'd0, bits})) begin
            cls = CLS_ZERO;
        end else begin
            cls = CLS_SUB;
            s = ssub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_cls  <= cls;
            r2_neg  <= r1_rec.neg;
            r2_wide <= r1_rec.wide;
            r2_ok   <= r1_rec.ok;
            r2_acc  <= r1_rec.acc;
            r2_eb   <= eb;
            r2_left <= s < 19'sd0;
            r2_amt  <= (s < 19'sd0) ? 7'(-s) : 7'(s);
        end
    end

    // Stage 3: shift and round decision
    logic [63:0] q;
    logic [6:0]  am1;
    logic        rnd;
    always_comb begin
        am1 = r2_amt - 7'd1;
        rnd = 1'b0;
        if (r2_left) begin
            q = r2_acc << r2_amt;
        end else if (r2_amt == 7'd0) begin
            q = r2_acc;
        end else begin
            q = r2_acc >> r2_amt;
            rnd = r2_acc[am1[5:0]]
                & ((|(r2_acc & ~({64{1'b1}} << am1))) | q[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_cls  <= r2_cls;
            r3_neg  <= r2_neg;
            r3_wide <= r2_wide;
            r3_ok   <= r2_ok;
            r3_eb   <= r2_eb;
            r3_q    <= q;
            r3_rnd  <= rnd;
        end
    end

    // Output stage: increment, renormalize, encode
    logic [63:0] m, mm, sgn, inf, smask;
    logic [11:0] eb1, ebmax;
    logic        carry;
    always_comb begin
        m = r3_q + {63'd0, r3_rnd};
        carry = r3_wide ? m[53] : m[24];
        mm = carry ? (m >> 1) : m;
        eb1 = r3_eb + {11'd0, carry};
        ebmax = r3_wide ? 12'd2046 : 12'd254;
        sgn = r3_wide ? {r3_neg, 63'd0} : {32'd0, r3_neg, 31'd0};
        inf = sgn | (r3_wide ? hflt_pkg::F64_EXP_ALL : hflt_pkg::F32_EXP_ALL);
        smask = r3_wide ? hflt_pkg::F64_FRAC_MASK : hflt_pkg::F32_FRAC_MASK;
        n_res.ok = 1'b1;
        unique case (r3_cls)
            CLS_SPEC: begin
                n_res.result_bits = r3_q;
                n_res.ok = r3_ok;
            end
            CLS_ZERO: n_res.result_bits = sgn;
            CLS_INF:  n_res.result_bits = inf;
            CLS_NORM: begin
                if (eb1 > ebmax) n_res.result_bits = inf;
                else n_res.result_bits = sgn | (mm & smask)
                    | (r3_wide ? ({52'd0, eb1} << 52) : ({52'd0, eb1} << 23));
            end
            CLS_SUB:  n_res.result_bits = sgn | m;
            default:  n_res.result_bits = sgn;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r_ov <= 1'b0;
        end else if (adv) begin
            r1_v <= i_avail;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_ov <= r3_v;
        end
    end

endmodule
`default_nettype wire

// ===== sv/hex_float_literal_to_ieee_bits.sv =====
// Top level: hex float, infinity and NaN literal text to IEEE binary32/64 bits.
//
//   channel   direction  valid     stall     payload
//   request   in         i_valid   o_stall   i_req  (command, precision, character, last)
//   result    out        o_valid   i_stall   o_res  (result_bits, ok)
//
// One character request is taken every cycle while the record queue has room.
// The last character of a literal pushes one record; the converter pipeline
// (leading-bit search, class and shift, shift and round, encode into the output
// register) accepts a new record every cycle while no result is held.
// A held result stalls the whole converter pipeline; a full queue raises o_stall.
// Synchronous active-low reset returns the parser to the start of a literal.
`default_nettype none
module hex_float_literal_to_ieee_bits (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  hflt_pkg::t_req   i_req,
    output logic             o_valid,
    input  wire              i_stall,
    output hflt_pkg::t_res   o_res
);

    logic           accept, push, pop, full, avail;
    hflt_pkg::t_rec rec_in, rec_out;

    // Hold requests off while the queue is full
    assign o_stall = full;
    assign accept  = i_valid && !full;

    hflt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_push   (push),
        .o_rec    (rec_in)
    );

    hflt_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (rec_in),
        .i_pop    (pop),
        .o_full   (full),
        .o_avail  (avail),
        .o_rec    (rec_out)
    );

    hflt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (avail),
        .i_rec    (rec_out),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res    (o_res)
    );

endmodule
`default_nettype wire
